>>> hdl/rssn_pkg.sv
`timescale 1ns / 1ps

package rssn_pkg;

   // Field widths
   localparam int COORD_W    = 24;
   localparam int RADIUS_W   = 23;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DIST_W     = 50;
   localparam int INDEX_W    = 16;
   localparam int RSQ_W      = 2 * RADIUS_W;

   // Stream and register port widths
   localparam int REQ_DATA_W  = 3 * COORD_W;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COORD_W;

   // Defaults for the top level parameters
   localparam int DEF_MAX_KEPT   = 32;
   localparam int DEF_MAX_POINTS = 65536;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd2560;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_X = 2'd0,
      CSR_TARGET_Y = 2'd1,
      CSR_TARGET_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   // One slot of the sorted list.
   typedef struct packed {
      logic               valid;
      logic [DIST_W-1:0]  sq_dist;
      logic [INDEX_W-1:0] index;
   } entry_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic               insert;
      logic               shift;
      logic [DIST_W-1:0]  sq_dist;
      logic [INDEX_W-1:0] index;
   } cell_ctl_type;

   // A point leaving the distance pipeline.
   typedef struct packed {
      logic               valid;
      logic               last;
      logic               hit;
      logic [DIST_W-1:0]  sq_dist;
      logic [INDEX_W-1:0] index;
   } cand_type;

endpackage

>>> hdl/rssn_dist_pipe.sv
`timescale 1ns / 1ps

module rssn_dist_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [rssn_pkg::COORD_W-1:0]        coord_x,
   input  logic [rssn_pkg::COORD_W-1:0]        coord_y,
   input  logic [rssn_pkg::COORD_W-1:0]        coord_z,
   input  logic                                is_alpha_carbon,
   input  logic                                last_point,
   input  logic [rssn_pkg::INDEX_W-1:0]        point_index,
   input  logic [rssn_pkg::COORD_W-1:0]        target_x,
   input  logic [rssn_pkg::COORD_W-1:0]        target_y,
   input  logic [rssn_pkg::COORD_W-1:0]        target_z,
   input  logic [rssn_pkg::RADIUS_W-1:0]       search_radius,
   output rssn_pkg::cand_type                  cand
);
   import rssn_pkg::*;

   // Magnitude of the difference of two signed coordinates; it always fits
   // in COORD_W bits because both operands are COORD_W-bit signed values.
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[COORD_W-1:0];
   endfunction

   logic [RSQ_W-1:0]   rsq_ff;
   logic [RSQ_W-1:0]   rsq_in;

   // Stage 1: absolute differences
   logic               v1_ff, v1_in;
   logic               last1_ff, alpha1_ff;
   logic [INDEX_W-1:0] idx1_ff;
   logic [COORD_W-1:0] mx_ff, my_ff, mz_ff;

   // Stage 2: squares
   logic               v2_ff, v2_in;
   logic               last2_ff, alpha2_ff;
   logic [INDEX_W-1:0] idx2_ff;
   logic [SQ_W-1:0]    sx_ff, sy_ff, sz_ff;

   // Stage 3: sum and radius compare
   logic               v3_ff, v3_in;
   logic               last3_ff, hit3_ff, hit3_in;
   logic [INDEX_W-1:0] idx3_ff;
   logic [DIST_W-1:0]  sum3_ff, sum3_in;

   assign rsq_in  = search_radius * search_radius;
   assign v1_in   = in_valid;
   assign v2_in   = v1_ff;
   assign v3_in   = v2_ff;
   assign sum3_in = DIST_W'(sx_ff) + DIST_W'(sy_ff) + DIST_W'(sz_ff);
   assign hit3_in = alpha2_ff && (sum3_in < DIST_W'(rsq_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      rsq_ff    <= rsq_in;

      mx_ff     <= abs_diff(coord_x, target_x);
      my_ff     <= abs_diff(coord_y, target_y);
      mz_ff     <= abs_diff(coord_z, target_z);
      last1_ff  <= last_point;
      alpha1_ff <= is_alpha_carbon;
      idx1_ff   <= point_index;

      sx_ff     <= mx_ff * mx_ff;
      sy_ff     <= my_ff * my_ff;
      sz_ff     <= mz_ff * mz_ff;
      last2_ff  <= last1_ff;
      alpha2_ff <= alpha1_ff;
      idx2_ff   <= idx1_ff;

      sum3_ff   <= sum3_in;
      hit3_ff   <= hit3_in;
      last3_ff  <= last2_ff;
      idx3_ff   <= idx2_ff;
   end

   assign cand.valid   = v3_ff;
   assign cand.last    = last3_ff;
   assign cand.hit     = hit3_ff;
   assign cand.sq_dist = sum3_ff;
   assign cand.index   = idx3_ff;

endmodule

>>> hdl/rssn_cell.sv
`timescale 1ns / 1ps

module rssn_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  rssn_pkg::cell_ctl_type  ctl,
   input  rssn_pkg::entry_type     prev_entry,
   input  logic                    prev_keep,
   input  rssn_pkg::entry_type     next_entry,
   output rssn_pkg::entry_type     entry,
   output logic                    keep
);
   import rssn_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // A cell keeps its entry when the newcomer sorts after it (ties included).
   assign keep = entry_ff.valid && (entry_ff.sq_dist <= ctl.sq_dist);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = next_entry;
      end else if (ctl.insert && !keep) begin
         if (prev_keep) begin
            entry_in.valid   = 1'b1;
            entry_in.sq_dist = ctl.sq_dist;
            entry_in.index   = ctl.index;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

>>> hdl/radius_sorted_neighbor_select_unit.sv
`timescale 1ns / 1ps

// Radius-limited nearest neighbor selector.
// Base points arrive on the req_ stream, one word per point, and each gets an
// arrival index. Eligible points strictly inside the programmed radius of the
// target are kept in a list sorted by squared distance, ties in arrival order.
// The word with req_tlast ends the query: after it the list is sent out on the
// rsp_ stream nearest first, one word per kept point, rsp_tlast on the final
// one. An empty list gives one word with entry_valid low.
// Throughput: one point per cycle while a query runs. The sorted list is a
// chain of MAX_KEPT cells that all compare against the incoming distance in
// the same cycle, so an insertion never stalls the input.
// A point passes the difference, square and sum-and-compare registers before
// it enters the list. The first result word goes valid once the last point
// has reached the list; req_tready stays low from that point's acceptance
// until the final result word is taken.
// A stalled receiver simply holds the head of the chain on rsp_; nothing is
// lost. Reset clears the list, the index counter, the overflow flag and
// loads the register defaults (target at the origin, radius 10.0).
// Users must write csr_ registers only while the block is idle; not enforced.

module radius_sorted_neighbor_select_unit #(
   parameter int MAX_KEPT   = rssn_pkg::DEF_MAX_KEPT,
   parameter int MAX_POINTS = rssn_pkg::DEF_MAX_POINTS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // coord_x [23:0], coord_y [47:24], coord_z [71:48]
   input  logic [rssn_pkg::REQ_DATA_W-1:0]     req_tdata,
   // is_alpha_carbon [0]
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // point_index [15:0], distance_sq [65:16], zero fill [71:66]
   output logic [rssn_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // entry_valid [0], list_overflow [1]
   output logic [rssn_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   // Register write port
   input  logic                                csr_we,
   input  logic [rssn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rssn_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rssn_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS);
   localparam int PAD_W = RSP_DATA_W - DIST_W - INDEX_W;

   // Configuration registers
   logic [COORD_W-1:0]  target_x_ff;
   logic [COORD_W-1:0]  target_y_ff;
   logic [COORD_W-1:0]  target_z_ff;
   logic [RADIUS_W-1:0] radius_ff;

   // Query control
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W+INDEX_W-1:0] count_wide;
   logic                  overflow_ff, overflow_in;

   logic                  req_accept;
   logic                  rsp_accept;
   logic                  drain_done;

   cand_type              cand;
   cell_ctl_type          cell_ctl;
   entry_type             cell_entry [MAX_KEPT];
   logic                  cell_keep  [MAX_KEPT];
   entry_type             head;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign drain_done = rsp_accept && rsp_tlast;

   // Register writes. Every index of the 2-bit port names a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= '0;
         target_y_ff <= '0;
         target_z_ff <= '0;
         radius_ff   <= RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_X: target_x_ff <= csr_wdata;
            CSR_TARGET_Y: target_y_ff <= csr_wdata;
            CSR_TARGET_Z: target_z_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[RADIUS_W-1:0];
            default:      radius_ff   <= radius_ff;
         endcase
      end
   end

   // Arrival index counts modulo MAX_POINTS; the output carries its low bits.
   always_comb begin
      count_in = count_ff;
      if (drain_done) begin
         count_in = '0;
      end else if (req_accept) begin
         count_in = (count_ff == CNT_W'(MAX_POINTS - 1)) ? '0 : count_ff + 1'b1;
      end
   end

   assign count_wide = {{INDEX_W{1'b0}}, count_ff};

   // Any qualifying point that arrives while the last cell is occupied means
   // at least one point has been, or is about to be, pushed out of the list.
   always_comb begin
      overflow_in = overflow_ff;
      if (drain_done) begin
         overflow_in = 1'b0;
      end else if (cell_ctl.insert && cell_entry[MAX_KEPT-1].valid) begin
         overflow_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Next state: accept points, wait for the last one to reach the list,
   // then stream the list out.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (req_accept && req_tlast) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (cand.valid && cand.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_RUN:   req_tready = 1'b1;
         ST_FLUSH: req_tready = 1'b0;
         ST_DRAIN: rsp_tvalid = 1'b1;
         default:  req_tready = 1'b0;
      endcase
   end

   rssn_dist_pipe u_dist (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_accept),
      .coord_x         (req_tdata[COORD_W-1:0]),
      .coord_y         (req_tdata[2*COORD_W-1:COORD_W]),
      .coord_z         (req_tdata[3*COORD_W-1:2*COORD_W]),
      .is_alpha_carbon (req_tuser),
      .last_point      (req_tlast),
      .point_index     (count_wide[INDEX_W-1:0]),
      .target_x        (target_x_ff),
      .target_y        (target_y_ff),
      .target_z        (target_z_ff),
      .search_radius   (radius_ff),
      .cand            (cand)
   );

   // The chain inserts a qualifying point straight from the distance pipeline;
   // during the drain it shifts toward cell 0, which drives the result port.
   assign cell_ctl.insert  = cand.valid && cand.hit;
   assign cell_ctl.shift   = rsp_accept;
   assign cell_ctl.sq_dist = cand.sq_dist;
   assign cell_ctl.index   = cand.index;

   for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      logic      prev_k;

      if (g == 0) begin : g_first
         assign prev_e = '0;
         assign prev_k = 1'b1;
      end else begin : g_inner
         assign prev_e = cell_entry[g-1];
         assign prev_k = cell_keep[g-1];
      end

      if (g == MAX_KEPT - 1) begin : g_tail
         assign next_e = '0;
      end else begin : g_body
         assign next_e = cell_entry[g+1];
      end

      rssn_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .prev_entry (prev_e),
         .prev_keep  (prev_k),
         .next_entry (next_e),
         .entry      (cell_entry[g]),
         .keep       (cell_keep[g])
      );
   end

   // An empty list still yields one word, with zero index and distance.
   assign head      = cell_entry[0];
   assign rsp_tdata = head.valid ? {{PAD_W{1'b0}}, head.sq_dist, head.index}
                                 : '0;
   assign rsp_tuser = {overflow_ff, head.valid};
   assign rsp_tlast = !cell_entry[1].valid;

endmodule
